// ===== rtl/fvtng_pkg.sv =====
// Shared types, register codes and helpers for the four-voice tone/noise generator.
// Used by fvtng_voice and the top level four_voice_tone_noise_generator.
package fvtng_pkg;

    localparam int unsigned NumVoices = 4;

    // Register select within a voice (address bits 1:0)
    localparam logic [1:0] REG_PERIOD_LO = 2'd0;
    localparam logic [1:0] REG_PERIOD_HI = 2'd1;
    localparam logic [1:0] REG_MODE_VOL  = 2'd2;
    localparam logic [1:0] REG_DIVIDER   = 2'd3;

    // Noise modes
    localparam logic [1:0] MODE_SQUARE = 2'd0;
    localparam logic [1:0] MODE_TAP    = 2'd1;
    localparam logic [1:0] MODE_ROTATE = 2'd2;
    localparam logic [1:0] MODE_RING   = 2'd3;

    // Operation codes carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Per-voice request, decoded by the top level
    typedef struct packed {
        logic       wr_en;
        logic       tick;
        logic [1:0] reg_sel;
        logic [7:0] data;
        logic       offset_neg;
    } t_voice_req;

    // floor(127*vol/31) = 4*vol + floor(3*vol/31)
    function automatic logic [6:0] level_of(input logic [4:0] vol);
        logic [6:0] v3;
        logic [1:0] frac;
        v3 = 7'(vol) * 7'd3;
        if (v3 >= 7'd93) begin
            frac = 2'd3;
        end else if (v3 >= 7'd62) begin
            frac = 2'd2;
        end else if (v3 >= 7'd31) begin
            frac = 2'd1;
        end else begin
            frac = 2'd0;
        end
        return {vol, 2'b00} + 7'(frac);
    endfunction

endpackage

// ===== rtl/fvtng_voice.sv =====
// One voice: period/mode/volume/divider registers, tone counter, LFSR and
// second oscillator. Depends on fvtng_pkg.
module fvtng_voice
    import fvtng_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_voice_req i_req,
    output logic       o_gate,
    output logic [6:0] o_level
);

    logic [15:0]        r_period, n_period;
    logic [1:0]         r_mode, n_mode;
    logic [4:0]         r_volume, n_volume;
    logic [6:0]         r_divider, n_divider;
    logic [15:0]        r_sr, n_sr;
    logic [15:0]        r_tone_cnt, n_tone_cnt;   // never negative once stored
    logic signed [17:0] r_aux_cnt, n_aux_cnt;
    logic               r_carrier, n_carrier;

    logic               tone_reload;
    logic signed [17:0] aux_dec;
    logic signed [17:0] aux_inc;
    logic signed [17:0] aux_reload;
    logic signed [17:0] aux_limit;

    always_comb begin
        n_period   = r_period;
        n_mode     = r_mode;
        n_volume   = r_volume;
        n_divider  = r_divider;
        n_sr       = r_sr;
        n_tone_cnt = r_tone_cnt;
        n_aux_cnt  = r_aux_cnt;
        n_carrier  = r_carrier;

        // tone counter hits zero or below after decrement
        tone_reload = (r_tone_cnt <= 16'd1);
        aux_dec     = r_aux_cnt - 18'sd1;
        aux_inc     = r_aux_cnt + 18'sd1;
        aux_limit   = $signed({7'd0, r_divider, 4'd0});
        if (i_req.offset_neg) begin
            aux_reload = $signed({2'b00, r_period}) - $signed({11'd0, r_divider});
        end else begin
            aux_reload = $signed({2'b00, r_period}) + $signed({11'd0, r_divider});
        end

        if (i_req.wr_en) begin
            unique case (i_req.reg_sel)
                REG_PERIOD_LO: n_period = {r_period[15:8], i_req.data};
                REG_PERIOD_HI: n_period = {i_req.data, r_period[7:0]};
                REG_MODE_VOL: begin
                    n_mode   = i_req.data[7:6];
                    n_volume = i_req.data[4:0];
                end
                REG_DIVIDER: begin
                    n_divider = i_req.data[6:0];
                    if (i_req.data[7]) begin
                        n_sr       = 16'd1;
                        n_tone_cnt = '0;
                        n_aux_cnt  = '0;
                    end
                end
                default: ;
            endcase
        end else if (i_req.tick) begin
            if (tone_reload) begin
                n_tone_cnt = r_period;
                case (r_mode)
                    MODE_TAP: begin
                        n_sr      = {r_sr[0] ^ r_sr[3], r_sr[15:1]};
                        n_carrier = n_sr[0];
                    end
                    MODE_ROTATE: begin
                        n_sr      = {r_sr[0], r_sr[15:1]};
                        n_carrier = n_sr[0];
                    end
                    default: n_carrier = ~r_carrier;
                endcase
            end else begin
                n_tone_cnt = r_tone_cnt - 16'd1;
            end

            if (r_mode == MODE_RING) begin
                if (aux_dec <= 18'sd0) begin
                    n_aux_cnt = aux_reload;
                    n_sr[0]   = ~n_sr[0];
                end else begin
                    n_aux_cnt = aux_dec;
                end
            end else if (r_divider != 7'd0) begin
                if (aux_inc >= aux_limit) begin
                    n_aux_cnt = '0;
                    n_sr      = 16'd1;
                end else begin
                    n_aux_cnt = aux_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= '0;
            r_mode     <= MODE_SQUARE;
            r_volume   <= '0;
            r_divider  <= '0;
            r_sr       <= 16'd1;
            r_tone_cnt <= '0;
            r_aux_cnt  <= '0;
            r_carrier  <= 1'b0;
        end else begin
            r_period   <= n_period;
            r_mode     <= n_mode;
            r_volume   <= n_volume;
            r_divider  <= n_divider;
            r_sr       <= n_sr;
            r_tone_cnt <= n_tone_cnt;
            r_aux_cnt  <= n_aux_cnt;
            r_carrier  <= n_carrier;
        end
    end

    // ring mode: carrier XOR LFSR bit 0
    assign o_gate  = (r_mode == MODE_RING) ? (n_carrier ^ n_sr[0]) : n_carrier;
    assign o_level = level_of(r_volume);

endmodule

// ===== rtl/four_voice_tone_noise_generator.sv =====
// Four-voice tone/noise generator top level. A tick request's result appears on the
// master side in the cycle after acceptance. Throughput: one request per cycle unless
// the result stalls; register writes produce no result. The output register decouples
// the sides, so a request is taken whenever the result register is empty or drains.
// Synchronous active-low reset: voice registers cleared, LFSRs set to 1, output empty.
// Depends on fvtng_pkg and fvtng_voice.
module four_voice_tone_noise_generator
    import fvtng_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,     // mode3_offset_negative, bit per voice
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,    // [3:0] address, [11:4] data, [15:12] zero
    input  logic        i_s_axis_tuser,    // [0] operation (0 write, 1 tick)
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0..3] voice0..3 gate, [10:4] voice0 level, [17:11] voice1 level,
    // [24:18] voice2 level, [31:25] voice3 level
    output logic [31:0] o_m_axis_tdata
);

    logic [3:0]  r_offset_neg;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        s_accept;
    logic        tick_accept;
    logic [3:0]  gate;
    logic [6:0]  level [NumVoices];
    t_voice_req  req [NumVoices];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign tick_accept     = s_accept && (i_s_axis_tuser == OP_TICK);

    for (genvar v = 0; v < NumVoices; v++) begin : g_voice
        always_comb begin
            req[v].wr_en      = s_accept && (i_s_axis_tuser == OP_WRITE)
                                && (i_s_axis_tdata[3:2] == 2'(v));
            req[v].tick       = tick_accept;
            req[v].reg_sel    = i_s_axis_tdata[1:0];
            req[v].data       = i_s_axis_tdata[11:4];
            req[v].offset_neg = r_offset_neg[v];
        end

        fvtng_voice u_voice (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (req[v]),
            .o_gate  (gate[v]),
            .o_level (level[v])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_neg <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_offset_neg <= i_cfg_wr_data;
            end
            if (tick_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_out_data <= {level[3], level[2], level[1], level[0], gate};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_accept |=> o_m_axis_tvalid)
        else $error("tick request did not produce a result");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid && s_accept && (i_s_axis_tuser == OP_WRITE)) |=> !o_m_axis_tvalid)
        else $error("register write produced a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !s_accept)
        else $error("request accepted while result stalled");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

endmodule
